// ----- hdl/ess_pkg.sv -----
`timescale 1ns / 1ps

package ess_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int DATA_W      = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_EXP,
    S_BIN
  } state_t;

endpackage

// ----- hdl/exponential_search_sorted_table_top.sv -----
`timescale 1ns / 1ps

// exponential search over a sorted table of signed 32-bit entries. an item with
// in_operation = load writes in_value at in_position and gives no result; busy
// stays low. an item with in_operation = search looks for in_value
// among the first table_length entries (cfg_wr_data, 0 read as 1, clamped to the
// table depth): entry 0 first, then a bound doubling from 1 while it stays inside
// the used length and the entry there is at most the key, then a binary search
// between half the bound and the lesser of the bound and the last used entry.
// the table is one single-port memory with a registered read, and the sequencer
// probes exactly one entry per cycle while a search runs. busy stays high while
// a search runs and is low again in the cycle in which the result strobe is shown.
// the result is shown for exactly one cycle on out_found / out_match_position,
// marked by out_valid; the receiver cannot stall it, and a new item may be
// started in the same cycle that the strobe is high. entries must be loaded
// before a search reads them; table_length is only to be written while the
// block idles, and the block itself does not enforce this.
module exponential_search_sorted_table_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_operation,
  input  logic [ess_pkg::ADDR_W-1:0]       in_position,
  input  logic signed [ess_pkg::DATA_W-1:0] in_value,
  output logic                             out_valid,
  output logic                             out_found,
  output logic [ess_pkg::ADDR_W-1:0]       out_match_position,
  input  logic                             cfg_wr_en,
  input  logic [ess_pkg::LEN_W-1:0]        cfg_wr_data
);

  // table storage, written on a load item, read one entry per cycle
  logic signed [ess_pkg::DATA_W-1:0] mem [ess_pkg::TABLE_DEPTH];
  logic signed [ess_pkg::DATA_W-1:0] rd_data_r;
  logic                              rd_en;
  ess_pkg::addr_t                    rd_addr;
  logic                              wr_en;

  // configuration
  ess_pkg::len_t table_length_r;
  ess_pkg::len_t used_len;

  // sequencer state
  ess_pkg::state_t                   state_r, state_nxt;
  logic signed [ess_pkg::DATA_W-1:0] key_r, key_nxt;
  ess_pkg::len_t                     n_r, n_nxt;       // used length for this search
  ess_pkg::len_t                     bound_r, bound_nxt;
  ess_pkg::len_t                     lo_r, lo_nxt;     // binary search, inclusive low
  ess_pkg::len_t                     r1_r, r1_nxt;     // binary search, exclusive high
  ess_pkg::addr_t                    probe_r, probe_nxt; // address of rd_data_r

  // result register
  logic           out_valid_r, out_valid_nxt;
  logic           out_found_r, out_found_nxt;
  ess_pkg::addr_t out_pos_r, out_pos_nxt;

  // compare against the probed entry
  logic eq, le, lt;

  // binary search setup from a bound
  ess_pkg::len_t  bound2;
  ess_pkg::len_t  bin_b;
  ess_pkg::len_t  bs_hi, bs_r1, bs_l, bs_sum;
  ess_pkg::addr_t bs_mid;

  // binary search step
  ess_pkg::len_t  nl, nr, n_sum;
  ess_pkg::addr_t nmid;

  assign busy               = (state_r != ess_pkg::S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_match_position = out_pos_r;

  assign wr_en = start && !busy && (ess_pkg::op_t'(in_operation) == ess_pkg::OP_LOAD);

  // zero counts as one, anything past the depth saturates
  always_comb begin
    if (table_length_r == '0) begin
      used_len = ess_pkg::LEN_W'(1);
    end else if (table_length_r > ess_pkg::LEN_W'(ess_pkg::TABLE_DEPTH)) begin
      used_len = ess_pkg::LEN_W'(ess_pkg::TABLE_DEPTH);
    end else begin
      used_len = table_length_r;
    end
  end

  assign eq = (rd_data_r == key_r);
  assign le = (rd_data_r <= key_r);
  assign lt = (rd_data_r <  key_r);

  assign bound2 = {bound_r[ess_pkg::LEN_W-2:0], 1'b0};

  // bound where doubling stops: 1 after the head probe, else the current or doubled bound
  always_comb begin
    if (state_r == ess_pkg::S_EXP) begin
      bin_b = le ? bound2 : bound_r;
    end else begin
      bin_b = ess_pkg::LEN_W'(1);
    end
    bs_hi  = (bin_b < n_r) ? bin_b : (n_r - ess_pkg::LEN_W'(1));
    bs_r1  = bs_hi + ess_pkg::LEN_W'(1);
    bs_l   = bin_b >> 1;
    bs_sum = bs_l + bs_r1 - ess_pkg::LEN_W'(1);
    bs_mid = bs_sum[ess_pkg::LEN_W-1:1];
  end

  // narrow the interval around the probed midpoint
  always_comb begin
    if (lt) begin
      nl = {1'b0, probe_r} + ess_pkg::LEN_W'(1);
      nr = r1_r;
    end else begin
      nl = lo_r;
      nr = {1'b0, probe_r};
    end
    n_sum = nl + nr - ess_pkg::LEN_W'(1);
    nmid  = n_sum[ess_pkg::LEN_W-1:1];
  end

  // sequencer: one table probe per cycle
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    n_nxt         = n_r;
    bound_nxt     = bound_r;
    lo_nxt        = lo_r;
    r1_nxt        = r1_r;
    probe_nxt     = probe_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    rd_en         = 1'b0;
    rd_addr       = probe_r;

    case (state_r)
      ess_pkg::S_IDLE: begin
        if (start && (ess_pkg::op_t'(in_operation) == ess_pkg::OP_SEARCH)) begin
          key_nxt   = in_value;
          n_nxt     = used_len;
          rd_en     = 1'b1;
          rd_addr   = '0;
          state_nxt = ess_pkg::S_HEAD;
        end
      end

      ess_pkg::S_HEAD, ess_pkg::S_EXP: begin
        if ((state_r == ess_pkg::S_HEAD) && eq) begin
          // hit on entry 0
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_pos_nxt   = '0;
          state_nxt     = ess_pkg::S_IDLE;
        end else if ((state_r == ess_pkg::S_HEAD) && (n_r > ess_pkg::LEN_W'(1))) begin
          bound_nxt = ess_pkg::LEN_W'(1);
          rd_en     = 1'b1;
          rd_addr   = ess_pkg::ADDR_W'(1);
          state_nxt = ess_pkg::S_EXP;
        end else if ((state_r == ess_pkg::S_EXP) && le && (bound2 < n_r)) begin
          // keep doubling
          bound_nxt = bound2;
          rd_en     = 1'b1;
          rd_addr   = bound2[ess_pkg::ADDR_W-1:0];
        end else if (bs_l < bs_r1) begin
          // start binary search
          lo_nxt    = bs_l;
          r1_nxt    = bs_r1;
          rd_en     = 1'b1;
          rd_addr   = bs_mid;
          state_nxt = ess_pkg::S_BIN;
        end else begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_pos_nxt   = '0;
          state_nxt     = ess_pkg::S_IDLE;
        end
      end

      ess_pkg::S_BIN: begin
        if (eq) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_pos_nxt   = probe_r;
          state_nxt     = ess_pkg::S_IDLE;
        end else if (nl < nr) begin
          lo_nxt  = nl;
          r1_nxt  = nr;
          rd_en   = 1'b1;
          rd_addr = nmid;
        end else begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_pos_nxt   = '0;
          state_nxt     = ess_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ess_pkg::S_IDLE;
      end
    endcase

    if (rd_en) begin
      probe_nxt = rd_addr;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ess_pkg::S_IDLE;
      out_valid_r    <= 1'b0;
      table_length_r <= ess_pkg::LEN_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        table_length_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    n_r         <= n_nxt;
    bound_r     <= bound_nxt;
    lo_r        <= lo_nxt;
    r1_r        <= r1_nxt;
    probe_r     <= probe_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_position] <= in_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // a result only ever follows a cycle of search work
  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r != ess_pkg::S_IDLE))
    else $error("result strobe without a search in progress");

  // the doubling bound never leaves the used length
  a_bound_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ess_pkg::S_EXP) |-> (bound_r < n_r))
    else $error("doubling bound outside used length");

  // the binary search interval is never empty while probing
  a_bin_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ess_pkg::S_BIN) |-> ((lo_r < r1_r) && (r1_r <= n_r)))
    else $error("binary search interval empty or past used length");

  // the used length latched for a search is clamped
  a_len_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ess_pkg::S_IDLE) |->
      ((n_r != '0) && (n_r <= ess_pkg::LEN_W'(ess_pkg::TABLE_DEPTH))))
    else $error("used length out of range during search");

endmodule

// ----- test/exponential_search_sorted_table_top_tb.sv -----
`timescale 1ns / 1ps

// checks exponential search over the sorted table; loads and searches are queued by
// an initial block, a clocked driver presents them on start/busy and updates a local
// mirror of the table when each item is taken, and a clocked monitor compares every
// out_valid strobe with the oldest predicted answer
module exponential_search_sorted_table_top_tb;

  localparam logic signed [ess_pkg::DATA_W-1:0] KEY_MIN = 32'sh80000000;
  localparam logic signed [ess_pkg::DATA_W-1:0] KEY_MAX = 32'sh7fffffff;
  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 100;

  // how a phase fills the used part of the table
  typedef enum int {
    FILL_SORTED,
    FILL_DUPS,
    FILL_SCRAMBLED,
    FILL_KEEP
  } fill_t;

  typedef struct {
    ess_pkg::op_t                       op;
    ess_pkg::addr_t                     pos;
    logic signed [ess_pkg::DATA_W-1:0]  val;
  } ess_item_t;

  typedef struct packed {
    logic           found;
    ess_pkg::addr_t match_pos;
  } search_answer_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic                               in_operation = 1'b0;
  logic [ess_pkg::ADDR_W-1:0]         in_position = '0;
  logic signed [ess_pkg::DATA_W-1:0]  in_value = '0;
  logic                               out_valid;
  logic                               out_found;
  logic [ess_pkg::ADDR_W-1:0]         out_match_position;
  logic                               cfg_wr_en = 1'b0;
  logic [ess_pkg::LEN_W-1:0]          cfg_wr_data = '0;

  // items waiting for the driver, and answers waiting for the monitor
  ess_item_t                          pending_commands[$];
  search_answer_t                     search_answers[$];
  ess_item_t                          presented_item;

  // table and length as the block holds them, updated at the accepting edge
  logic signed [ess_pkg::DATA_W-1:0]  entry_mirror[ess_pkg::TABLE_DEPTH];
  ess_pkg::len_t                      active_length;

  // table as planned by the stimulus side, so searches only touch written entries
  logic signed [ess_pkg::DATA_W-1:0]  plan_vals[ess_pkg::TABLE_DEPTH];
  bit                                 plan_written[ess_pkg::TABLE_DEPTH];

  int                                 queued_items = 0;
  int                                 gap_percent = 30;
  int                                 gap_left = 0;
  int                                 mismatches = 0;
  int                                 cycle_count = 0;

  exponential_search_sorted_table_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_match_position (out_match_position),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // expected answer of a search under the current length and mirror
  function automatic search_answer_t exp_search_answer(
    logic signed [ess_pkg::DATA_W-1:0] key
  );
    search_answer_t ans;
    int unsigned    n;
    int unsigned    bound;
    int unsigned    lo;
    int unsigned    hi_excl;
    int unsigned    mid;
    ans = '0;
    n = active_length;
    // zero length counts as one entry, oversize lengths clamp to the depth
    if (n < 1) n = 1;
    if (n > ess_pkg::TABLE_DEPTH) n = ess_pkg::TABLE_DEPTH;
    // entry 0 is checked on its own first
    if (entry_mirror[0] == key) begin
      ans.found = 1'b1;
      return ans;
    end
    // doubling phase: grow the bound while it is used and not above the key
    bound = 1;
    while (bound < n && entry_mirror[bound] <= key) bound = bound * 2;
    // binary phase over [bound/2, min(bound, n-1)], inclusive
    lo = bound / 2;
    hi_excl = ((bound < n) ? bound : n - 1) + 1;
    while (lo < hi_excl) begin
      mid = (lo + hi_excl - 1) / 2;
      if (entry_mirror[mid] == key) begin
        // with duplicates the first probe that hits wins
        ans.found = 1'b1;
        ans.match_pos = ess_pkg::addr_t'(mid);
        return ans;
      end
      if (entry_mirror[mid] < key) lo = mid + 1;
      else hi_excl = mid;
    end
    return ans;
  endfunction

  // driver: the item shown is taken at an edge where start is high and busy low
  always @(posedge clk) begin
    bit take;
    take = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
      active_length = ess_pkg::len_t'(1);
    end else begin
      if (cfg_wr_en) active_length = cfg_wr_data;
      if (take) begin
        if (presented_item.op == ess_pkg::OP_LOAD) begin
          entry_mirror[presented_item.pos] = presented_item.val;
        end else begin
          search_answers.push_back(exp_search_answer(presented_item.val));
        end
        // idle burst after this item
        if ($urandom_range(0, 99) < gap_percent) gap_left = $urandom_range(1, 9);
      end
      if (!start || take) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_commands.size() > 0) begin
          presented_item = pending_commands.pop_front();
          in_operation <= presented_item.op;
          in_position  <= presented_item.pos;
          in_value     <= presented_item.val;
          start        <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, so every strobe is checked at once
  always @(posedge clk) begin
    search_answer_t want;
    if (rst_n && out_valid) begin
      if (search_answers.size() == 0) begin
        $error("result with no search pending: found %0d, match_position %0d",
               out_found, out_match_position);
        mismatches++;
      end else begin
        want = search_answers.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_found);
          mismatches++;
        end
        if (out_match_position !== want.match_pos) begin
          $error("match_position: expected %0d, actual %0d", want.match_pos,
                 out_match_position);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_load(input ess_pkg::addr_t pos,
                            input logic signed [ess_pkg::DATA_W-1:0] val);
    ess_item_t it;
    it.op = ess_pkg::OP_LOAD;
    it.pos = pos;
    it.val = val;
    plan_vals[pos] = val;
    plan_written[pos] = 1'b1;
    pending_commands.push_back(it);
    queued_items++;
  endtask

  task automatic queue_search(input logic signed [ess_pkg::DATA_W-1:0] key);
    ess_item_t it;
    it.op = ess_pkg::OP_SEARCH;
    // position is a don't-care for a search, so toggle it anyway
    it.pos = ess_pkg::addr_t'($urandom);
    it.val = key;
    pending_commands.push_back(it);
    queued_items++;
  endtask

  // wait until every queued item is taken and every answer is back
  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending_commands.size() != 0 || start || search_answers.size() != 0);
  endtask

  // length is only changed with the block idle, after a settling pause
  task automatic set_table_length(input int unsigned len_value);
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ess_pkg::len_t'(len_value);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // one phase: new length, fresh table contents if needed, then searches with
  // some loads mixed in as noise
  task automatic run_phase(input int unsigned len_value, input fill_t fill_kind,
                           input int searches);
    int unsigned                       n;
    longint                            span;
    longint                            level;
    int                                r;
    int                                idx;
    bit                                need_fill;
    logic signed [ess_pkg::DATA_W-1:0] key;
    set_table_length(len_value);
    n = (len_value == 0) ? 1 :
        ((len_value > ess_pkg::TABLE_DEPTH) ? ess_pkg::TABLE_DEPTH : len_value);
    need_fill = (fill_kind != FILL_KEEP);
    for (int k = 0; k < n; k++) if (!plan_written[k]) need_fill = 1'b1;
    if (need_fill) begin
      span = (64'sd1 <<< 32) / longint'(n + 1);
      if (fill_kind == FILL_DUPS) level = longint'($signed($urandom));
      else level = -64'sd2147483648 + longint'($urandom_range(0, 1000));
      for (int k = 0; k < n; k++) begin
        if (fill_kind == FILL_SCRAMBLED) begin
          queue_load(ess_pkg::addr_t'(k), $urandom);
        end else begin
          queue_load(ess_pkg::addr_t'(k),
                     (level > 64'sd2147483647) ? KEY_MAX : level[ess_pkg::DATA_W-1:0]);
          // duplicates: steps of 0 or 1; sorted: random steps spanning the range
          if (fill_kind == FILL_DUPS) level += longint'($urandom_range(0, 1));
          else level += (longint'($urandom_range(0, 32'h7fffffff)) * span) >>> 30;
        end
      end
    end
    for (int s = 0; s < searches; s++) begin
      r = $urandom_range(0, 99);
      idx = $urandom_range(0, n - 1);
      if (r < 12) begin
        // noise load anywhere, may break the ordering
        queue_load(ess_pkg::addr_t'($urandom), $urandom);
      end else begin
        if (r < 60) key = plan_vals[idx];
        else if (r < 78) key = plan_vals[idx] + ($urandom_range(0, 1) ? 1 : -1);
        else if (r < 86) begin
          // key taken from anywhere in the table, also beyond the used length
          idx = $urandom_range(0, ess_pkg::TABLE_DEPTH - 1);
          key = plan_written[idx] ? plan_vals[idx] : $urandom;
        end else if (r < 93) key = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
        else key = $urandom;
        queue_search(key);
      end
    end
  endtask

  initial begin
    int          first_random;
    int          r;
    int unsigned len_value;
    fill_t       kind;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset length of one, extremes of key
    queue_load(ess_pkg::addr_t'(0), KEY_MIN);
    queue_search(KEY_MIN);
    queue_search(KEY_MAX);
    queue_search(32'sd0);
    // zero length behaves as one
    set_table_length(0);
    queue_search(KEY_MIN);
    // small table with a duplicate pair and the top value
    set_table_length(5);
    queue_load(ess_pkg::addr_t'(1), -32'sd7);
    queue_load(ess_pkg::addr_t'(2), -32'sd7);
    queue_load(ess_pkg::addr_t'(3), 32'sd100);
    queue_load(ess_pkg::addr_t'(4), KEY_MAX);
    queue_load(ess_pkg::addr_t'(ess_pkg::ADDR_W'('1)), 32'sh5555aaaa);
    queue_search(-32'sd7);
    queue_search(32'sd100);
    queue_search(KEY_MAX);
    queue_search(32'sd99);
    queue_search(KEY_MIN);
    // out-of-order entry: probes may pass a key that is present
    queue_load(ess_pkg::addr_t'(2), 32'sd500);
    queue_search(32'sd100);
    queue_search(32'sd500);

    // full depth, then lengths above the depth that must clamp
    run_phase(ess_pkg::TABLE_DEPTH, FILL_SORTED, 40);
    gap_percent = 0;
    run_phase(2047, FILL_KEEP, 30);
    gap_percent = 50;
    run_phase(ess_pkg::TABLE_DEPTH + 1, FILL_KEEP, 30);

    // random phases, mostly short tables
    first_random = queued_items;
    while (queued_items - first_random < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 5) len_value = 0;
      else if (r < 85) len_value = $urandom_range(1, 48);
      else len_value = $urandom_range(49, 300);
      r = $urandom_range(0, 99);
      if (r < 55) kind = FILL_SORTED;
      else if (r < 75) kind = FILL_DUPS;
      else if (r < 90) kind = FILL_SCRAMBLED;
      else kind = FILL_KEEP;
      r = $urandom_range(0, 2);
      gap_percent = (r == 0) ? 0 : ((r == 1) ? 25 : 60);
      run_phase(len_value, kind, $urandom_range(20, 60));
    end

    // last part runs back to back
    gap_percent = 0;
    run_phase(64, FILL_KEEP, 60);

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
